// File: sv/vcp_pkg.sv
package vcp_pkg;

  // Widths of the payload fields, of the pacing arithmetic and of the register port.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FrameW = 12;
  localparam int unsigned WaitW  = 18;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // Index of the frame size register in the register map.
  localparam logic RegFrameSamples = 1'b0;

  localparam logic [FrameW-1:0] FrameReset = 12'd737;

  // Command opcodes of the byte stream.
  localparam logic [ByteW-1:0] OpSkip  = 8'h4F;
  localparam logic [ByteW-1:0] OpPsg   = 8'h50;
  localparam logic [ByteW-1:0] OpWait  = 8'h61;
  localparam logic [ByteW-1:0] OpFrame = 8'h62;
  localparam logic [ByteW-1:0] OpEnd   = 8'h66;

  // Item kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

endpackage

// File: sv/vcp_cmd_if.sv
interface vcp_cmd_if;
  import vcp_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output op, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input op, input data_byte, input last_byte, output ready);

endinterface

// File: sv/vcp_res_if.sv
interface vcp_res_if;
  import vcp_pkg::*;

  logic             valid;
  logic             ready;
  logic             psg_valid;
  logic [ByteW-1:0] psg_data;
  logic             want_bytes;
  logic             byte_ignored;
  logic             frame_end;
  logic             song_done;

  modport source (output valid, output psg_valid, output psg_data, output want_bytes,
                  output byte_ignored, output frame_end, output song_done, input ready);
  modport sink   (input valid, input psg_valid, input psg_data, input want_bytes,
                  input byte_ignored, input frame_end, input song_done, output ready);

endinterface

// File: sv/vgm_command_pacer.sv
// Paces a VGM command byte stream against video frame ticks. Each transfer on
// cmd_i is either a stream byte or a frame tick and produces exactly one result
// transfer on res_o. The block takes one item per clock cycle at full rate.
// An accepted item is first held in an input register. The one-step decode
// and wait subtraction between that register and the result register then
// load its result into the result register when that one is empty or being
// taken. cmd_i.ready falls only while both registers hold items and the
// result is not being taken. The frame size register is written through the
// APB port at byte address 0 and must only be changed while no item is in
// flight.
module vgm_command_pacer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  vcp_cmd_if.sink                     cmd_i,
  vcp_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcp_pkg::AddrW-1:0]   paddr,
  input  logic [vcp_pkg::DataW-1:0]   pwdata,
  output logic [vcp_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import vcp_pkg::*;

  // Parser phases.
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhSkip = 3'd1;
  localparam logic [2:0] PhPsg  = 3'd2;
  localparam logic [2:0] PhWlo  = 3'd3;
  localparam logic [2:0] PhWhi  = 3'd4;

  // Most negative wait value; the wait saturates here under repeated ticks.
  localparam logic signed [WaitW:0] WaitMin = -(19'sd1 <<< (WaitW - 1));

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic [FrameW-1:0] frame_q;
  logic              reg_sel;

  assign reg_sel = (paddr[2] == RegFrameSamples);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DataW - FrameW){1'b0}}, frame_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      frame_q <= pwdata[FrameW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. A new item is taken whenever the register is empty or its
  // content moves on to the result register in the same cycle.
  // ---------------------------------------------------------------------------
  logic             in_valid_q;
  logic             in_op_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             advance;

  assign advance     = in_valid_q && (!res_o.valid || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_op_q   <= cmd_i.op;
      in_byte_q <= cmd_i.data_byte;
      in_last_q <= cmd_i.last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Pacing state and the single-step update for the item in the input register.
  // ---------------------------------------------------------------------------
  logic [2:0]              phase_q, phase_d;
  logic [ByteW-1:0]        wlo_q, wlo_d;
  logic signed [WaitW-1:0] wait_q, wait_d;
  logic                    ended_q, ended_d;

  logic                    wanted;
  logic                    wanted_d;
  logic signed [WaitW:0]   frame_s;
  logic signed [WaitW:0]   diff;
  logic                    r_psg_valid;
  logic [ByteW-1:0]        r_psg_data;
  logic                    r_ignored;
  logic                    r_frame_end;
  logic                    r_song_done;

  assign frame_s = signed'({{(WaitW + 1 - FrameW){1'b0}}, frame_q});
  assign wanted  = (signed'({wait_q[WaitW-1], wait_q}) < frame_s) && !ended_q;
  assign diff    = signed'({wait_q[WaitW-1], wait_q}) - frame_s;

  always_comb begin
    phase_d     = phase_q;
    wlo_d       = wlo_q;
    wait_d      = wait_q;
    ended_d     = ended_q;
    r_psg_valid = 1'b0;
    r_psg_data  = '0;
    r_ignored   = 1'b0;
    r_frame_end = 1'b0;
    r_song_done = 1'b0;

    if (in_op_q == KindByte) begin
      if (!wanted) begin
        // A refused byte leaves all state alone, its end mark included.
        r_ignored = 1'b1;
      end else begin
        unique case (phase_q)
          PhSkip: begin
            phase_d = PhIdle;
          end
          PhPsg: begin
            r_psg_valid = 1'b1;
            r_psg_data  = in_byte_q;
            phase_d     = PhIdle;
          end
          PhWlo: begin
            wlo_d   = in_byte_q;
            phase_d = PhWhi;
          end
          PhWhi: begin
            wait_d  = signed'({{(WaitW - 2 * ByteW){1'b0}}, in_byte_q, wlo_q});
            phase_d = PhIdle;
          end
          default: begin
            phase_d = PhIdle;
            case (in_byte_q)
              OpSkip:  phase_d = PhSkip;
              OpPsg:   phase_d = PhPsg;
              OpWait:  phase_d = PhWlo;
              OpFrame: wait_d  = signed'({{(WaitW - FrameW){1'b0}}, frame_q});
              OpEnd:   ended_d = 1'b1;
              default: ;
            endcase
          end
        endcase
        if (in_last_q) begin
          ended_d = 1'b1;
        end
      end
    end else begin
      // Frame tick: take one frame off the wait, saturating at the bottom.
      if (diff < WaitMin) begin
        wait_d = WaitMin[WaitW-1:0];
      end else begin
        wait_d = diff[WaitW-1:0];
      end
      if (diff <= 0) begin
        r_frame_end = 1'b1;
        if (ended_q) begin
          // Song complete: rewind the parser for the next pass of the data.
          r_song_done = 1'b1;
          wait_d      = '0;
          phase_d     = PhIdle;
          wlo_d       = '0;
          ended_d     = 1'b0;
        end
      end
    end

    wanted_d = (signed'({wait_d[WaitW-1], wait_d}) < frame_s) && !ended_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      wlo_q   <= '0;
      wait_q  <= '0;
      ended_q <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      wlo_q   <= wlo_d;
      wait_q  <= wait_d;
      ended_q <= ended_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic             res_valid_q;
  logic             psg_valid_q;
  logic [ByteW-1:0] psg_data_q;
  logic             want_q;
  logic             ignored_q;
  logic             frame_end_q;
  logic             song_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      psg_valid_q <= r_psg_valid;
      psg_data_q  <= r_psg_data;
      want_q      <= wanted_d;
      ignored_q   <= r_ignored;
      frame_end_q <= r_frame_end;
      song_done_q <= r_song_done;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.psg_valid    = psg_valid_q;
  assign res_o.psg_data     = psg_data_q;
  assign res_o.want_bytes   = want_q;
  assign res_o.byte_ignored = ignored_q;
  assign res_o.frame_end    = frame_end_q;
  assign res_o.song_done    = song_done_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_done_needs_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && song_done_q |-> frame_end_q)
    else $error("song done reported without a frame end");

  a_psg_not_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && psg_valid_q |-> !frame_end_q && !ignored_q)
    else $error("sound chip write reported together with a tick or a refused byte");

  a_ignored_not_wanted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && ignored_q |-> !want_q)
    else $error("refused byte reported while bytes are wanted");

  a_done_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && r_song_done |=> phase_q == PhIdle && !ended_q && wait_q == '0)
    else $error("parser not rewound after song done");

  a_full_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> cmd_i.ready)
    else $error("input stalled while the result register is empty");

endmodule

// File: sim/vgm_command_pacer_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the pacer, predicts the
// result of every accepted item and compares it with what the block returns.
module vgm_command_pacer_checker
  import vcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  vcp_cmd_if               cmd_i,
  vcp_res_if               res_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output int               fail_cnt_o,
  output int               pending_cnt_o,
  output int               checked_cnt_o,
  output int               parsed_cnt_o
);

  localparam logic [AddrW-1:0] FrameAddr = {RegFrameSamples, 2'b00};
  localparam int               WaitFloor = -(2 ** (WaitW - 1));

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhSkip   = 3'd1,
    PhPsg    = 3'd2,
    PhWaitLo = 3'd3,
    PhWaitHi = 3'd4
  } phase_e;

  typedef struct packed {
    logic             psg_valid;
    logic [ByteW-1:0] psg_data;
    logic             want_bytes;
    logic             byte_ignored;
    logic             frame_end;
    logic             song_done;
  } pacer_out_t;

  logic [FrameW-1:0]       frame_q;
  phase_e                  phase_q;
  logic [ByteW-1:0]        wait_lo_q;
  logic signed [WaitW-1:0] wait_q;
  logic                    ended_q;
  pacer_out_t              expected_q[$];

  function automatic logic bytes_wanted();
    return (int'(wait_q) < int'(frame_q)) && !ended_q;
  endfunction

  // Advances the predicted pacer state by one item and returns its result.
  function automatic pacer_out_t pace_item(input logic op, input logic [ByteW-1:0] b,
                                           input logic last);
    pacer_out_t r;
    int         w;
    r = '0;
    if (op == KindByte) begin
      if (!bytes_wanted()) begin
        r.byte_ignored = 1'b1;
      end else begin
        case (phase_q)
          PhSkip: phase_q = PhIdle;
          PhPsg: begin
            r.psg_valid = 1'b1;
            r.psg_data  = b;
            phase_q     = PhIdle;
          end
          PhWaitLo: begin
            wait_lo_q = b;
            phase_q   = PhWaitHi;
          end
          PhWaitHi: begin
            wait_q  = WaitW'({b, wait_lo_q});
            phase_q = PhIdle;
          end
          default: begin
            phase_q = PhIdle;
            case (b)
              OpSkip:  phase_q = PhSkip;
              OpPsg:   phase_q = PhPsg;
              OpWait:  phase_q = PhWaitLo;
              OpFrame: wait_q = WaitW'(frame_q);
              OpEnd:   ended_q = 1'b1;
              default: ;
            endcase
          end
        endcase
        if (last) ended_q = 1'b1;
      end
    end else begin
      w = int'(wait_q) - int'(frame_q);
      if (w < WaitFloor) w = WaitFloor;
      wait_q = WaitW'(w);
      if (w <= 0) begin
        r.frame_end = 1'b1;
        if (ended_q) begin
          r.song_done = 1'b1;
          wait_q      = '0;
          phase_q     = PhIdle;
          wait_lo_q   = '0;
          ended_q     = 1'b0;
        end
      end
    end
    r.want_bytes = bytes_wanted();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pacer_out_t exp_r;
    if (!rst_ni) begin
      frame_q       = FrameReset;
      phase_q       = PhIdle;
      wait_lo_q     = '0;
      wait_q        = '0;
      ended_q       = 1'b0;
      expected_q.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
      checked_cnt_o = 0;
      parsed_cnt_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == FrameAddr) begin
        frame_q = pwdata[FrameW-1:0];
      end
      if (cmd_i.valid && cmd_i.ready) begin
        exp_r = pace_item(cmd_i.op, cmd_i.data_byte, cmd_i.last_byte);
        expected_q.push_back(exp_r);
        if (!exp_r.byte_ignored) parsed_cnt_o++;
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer arrived with no item outstanding");
          fail_cnt_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("psg_valid", exp_r.psg_valid, res_i.psg_valid);
          check_field("psg_data", exp_r.psg_data, res_i.psg_data);
          check_field("want_bytes", exp_r.want_bytes, res_i.want_bytes);
          check_field("byte_ignored", exp_r.byte_ignored, res_i.byte_ignored);
          check_field("frame_end", exp_r.frame_end, res_i.frame_end);
          check_field("song_done", exp_r.song_done, res_i.song_done);
          checked_cnt_o++;
        end
      end
      pending_cnt_o = expected_q.size();
    end
  end

endmodule

// File: sim/vgm_command_pacer_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the VGM command pacer. A checker beside the block
// predicts every result; this module only produces transfers, programmes the
// frame size between phases and reports the outcome.
module vgm_command_pacer_tb;
  import vcp_pkg::*;

  localparam int               ClkPeriod = 10;
  localparam int               RstCycles = 11;
  localparam logic [AddrW-1:0] FrameAddr = {RegFrameSamples, 2'b00};

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int parsed_cnt;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls; they are changed twice during the run.
  int src_idle_pct;
  int snk_idle_pct;
  int frame_cfg;
  int items_sent;
  int last_frame;

  vcp_cmd_if cmd_if ();
  vcp_res_if res_if ();

  vgm_command_pacer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vgm_command_pacer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_if),
    .res_i         (res_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .checked_cnt_o (checked_cnt),
    .parsed_cnt_o  (parsed_cnt)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // The result side stalls independently of the command side. A fresh
  // decision is taken at every falling edge, so stalls land on every phase
  // of the pipeline.
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Offers one item and holds it until a transfer takes place. The task is
  // entered and left at a falling edge, so valid is only ever assigned once
  // per time step: either lowered for an idle cycle or kept high for the
  // next item.
  task automatic send_item(input logic op, input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.op        <= op;
    cmd_if.data_byte <= b;
    cmd_if.last_byte <= last;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    send_item(KindByte, b, last);
  endtask

  // The byte and last fields carry random values on ticks as well; the
  // block must disregard them.
  task automatic send_tick();
    send_item(KindTick, ByteW'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // A random byte for noise and unknown opcodes. With a very small frame a
  // stray wait command could load a count that takes tens of thousands of
  // ticks to drain, so there it is turned into a frame wait instead.
  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(255));
    if (b == OpWait && frame_cfg < 256) b = OpFrame;
    return b;
  endfunction

  // Random traffic until the pacer has taken n items. Most of it is
  // well-formed song material (PSG writes, skips, waits with the ticks that
  // drain them, stream ends followed by the ticks that finish the song);
  // the rest is loose noise and bursts of ticks long enough, with the
  // largest frame size, to drive the wait down to its floor.
  task automatic run_random(input int n);
    int start;
    int pick;
    int val;
    int reps;
    start = parsed_cnt;
    while (parsed_cnt - start < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(9))
            0, 1, 2: begin
              send_byte(OpPsg, 1'b0);
              send_byte(ByteW'($urandom_range(255)), 1'b0);
            end
            3: begin
              send_byte(OpSkip, 1'b0);
              send_byte(ByteW'($urandom_range(255)), 1'b0);
            end
            4, 5: begin
              // The full 16-bit range only where the frame is large enough
              // for the drain to stay short.
              if (frame_cfg >= 1024 && $urandom_range(7) == 0) begin
                val = $urandom_range(65535);
              end else begin
                val = $urandom_range(3 * frame_cfg);
              end
              send_byte(OpWait, 1'b0);
              send_byte(val[7:0], 1'b0);
              send_byte(val[15:8], 1'b0);
              reps = (val + frame_cfg - 1) / frame_cfg + $urandom_range(1);
              repeat (reps) send_tick();
            end
            6: begin
              send_byte(OpFrame, 1'b0);
              send_tick();
            end
            7: send_byte(pick_byte(), 1'b0);
            default: send_tick();
          endcase
        end
        case ($urandom_range(3))
          0: send_byte(OpEnd, 1'b0);
          1: send_byte(pick_byte(), 1'b1);
          default: ;
        endcase
        repeat ($urandom_range(1, 2)) send_tick();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(1)) send_tick();
          else send_byte(pick_byte(), $urandom_range(15) == 0);
        end
      end else begin
        reps = ($urandom_range(3) == 0) ? $urandom_range(36, 48) : $urandom_range(1, 8);
        repeat (reps) send_tick();
      end
    end
  endtask

  // Lets the pipeline drain: every item produces a result, so the block is
  // idle once the checker holds no outstanding prediction.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready is seen.
  task automatic set_frame(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FrameAddr;
    pwdata  <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    frame_cfg = value;
  endtask

  initial begin
    cmd_if.valid     = 1'b0;
    cmd_if.op        = KindByte;
    cmd_if.data_byte = '0;
    cmd_if.last_byte = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    src_idle_pct     = 11;
    snk_idle_pct     = 85;
    frame_cfg        = FrameReset;
    items_sent       = 0;

    repeat (RstCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, at the reset frame size of 737 samples.
    // PSG writes carrying the extreme data values.
    send_byte(OpPsg, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(OpPsg, 1'b0);
    send_byte(8'h00, 1'b0);
    // A skipped byte that looks like an end command must not end the stream.
    send_byte(OpSkip, 1'b0);
    send_byte(OpEnd, 1'b0);
    // An unknown opcode is consumed on its own.
    send_byte(8'h00, 1'b0);
    // Wait of 784 samples: more than a frame, so bytes are refused.
    send_byte(OpWait, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h03, 1'b0);
    // A refused byte leaves everything alone, its last mark included.
    send_byte(OpPsg, 1'b1);
    send_tick();
    // Frame wait, then the tick that brings the wait exactly to zero.
    send_byte(OpFrame, 1'b0);
    send_tick();
    // The stream ends inside a wait command; the command is abandoned and
    // the next tick completes the song.
    send_byte(OpWait, 1'b1);
    send_byte(8'h34, 1'b0);
    send_tick();
    // Stream end by command, then by a last byte that is also PSG data.
    send_byte(OpEnd, 1'b0);
    send_tick();
    send_byte(OpPsg, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_tick();
    send_byte(8'hFF, 1'b0);

    run_random(400);

    // Largest frame size: long tick bursts reach the wait floor here.
    settle();
    src_idle_pct = 85;
    snk_idle_pct = 11;
    set_frame(4095);
    run_random(400);

    // Smallest legal frame size, and from here on neither side idles.
    settle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_frame(1);
    run_random(400);

    // A frame size of zero: ticks subtract nothing and bytes are wanted only while the wait is negative.
    settle();
    set_frame(0);
    repeat (12) begin
      if ($urandom_range(1)) send_tick();
      else send_byte(ByteW'($urandom_range(255)), 1'($urandom_range(1)));
    end

    settle();
    last_frame = $urandom_range(2, 4094);
    set_frame(last_frame);
    run_random(300);

    settle();
    repeat (4) @(negedge clk_i);

    $display("Sent %0d items, %0d taken by the pacer, with frame sizes 737, 4095, 1, 0 and %0d.",
             items_sent, parsed_cnt, last_frame);
    $display("Compared %0d result transfers, %0d field errors.", checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
